[hdl/trht_pkg.sv]
// shared types and constants for the touch region hit test block
// no dependencies; imported by touch_region_hit_test
`timescale 1ns / 1ps
`default_nettype none

package trht_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int COORD_BITS  = 16;
    localparam int TAG_BITS    = 32;

    // entry index and fill count widths
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_TEST  = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_bound;
    typedef logic [TAG_BITS-1:0]   t_tag;

    // one region as stored in the table memory
    typedef struct packed {
        t_tag   tag_three;
        t_tag   tag_two;
        t_tag   tag_one;
        t_bound max_y;
        t_coord min_y;
        t_bound max_x;
        t_coord min_x;
    } t_entry;

    // one result item
    typedef struct packed {
        logic             hit;
        logic             full_res;
        t_tag             found_one;
        t_tag             found_two;
        t_tag             found_three;
        logic [CNT_W-1:0] region_count;
    } t_result;

endpackage

`default_nettype wire

[hdl/touch_region_hit_test.sv]
// touch region hit test top level: region table memory, scan sequencer, output register
// depends on trht_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_ready       | cmd, point, rectangle, three tags
// result    | out       | o_out_valid / i_out_ready     | hit, full, three found tags, count
//
// clear, add and the unused code go straight to S_DONE, skipping the scan
// a test reads the table one entry a cycle through the single read port, stopping
// at the first stored region that matches
// reset clears the fill count and the control state; table contents are only read below
// the fill count, so the memory needs no clearing
// a new item is taken while an earlier result still waits in the output register; only a
// second finished result waiting behind it holds the input side

module touch_region_hit_test (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [1:0]                       i_cmd,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_point_x,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_point_y,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_left,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_top,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_width,
    input  wire  [trht_pkg::COORD_BITS-1:0]  i_height,
    input  wire  [trht_pkg::TAG_BITS-1:0]    i_tag_one,
    input  wire  [trht_pkg::TAG_BITS-1:0]    i_tag_two,
    input  wire  [trht_pkg::TAG_BITS-1:0]    i_tag_three,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_hit,
    output logic                             o_full_res,
    output logic [trht_pkg::TAG_BITS-1:0]    o_found_one,
    output logic [trht_pkg::TAG_BITS-1:0]    o_found_two,
    output logic [trht_pkg::TAG_BITS-1:0]    o_found_three,
    output logic [trht_pkg::CNT_W-1:0]       o_region_count
);

    import trht_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;    // regions stored
    logic [CNT_W-1:0] r_idx, n_idx;        // next entry to read during a scan
    logic             r_rd_pend, n_rd_pend; // read data of the previous cycle is valid
    t_coord           r_px, n_px;
    t_coord           r_py, n_py;
    t_result          r_res, n_res;        // finished result waiting for the output register
    t_result          r_out, n_out;
    logic             r_out_valid, n_out_valid;

    // region table, one read and one write port
    t_entry           r_mem [MAX_REGIONS];
    t_entry           r_rd_data;
    t_entry           wr_data;
    logic             wr_en;
    logic             rd_en;

    logic             accept;
    logic             table_full;
    logic             match;
    logic             out_free;

    assign accept     = i_in_valid && o_in_ready;
    assign table_full = (r_count >= CNT_W'(MAX_REGIONS));
    assign out_free   = !r_out_valid || i_out_ready;

    // strict inside test on the entry read last cycle
    assign match = (r_rd_data.min_x < r_px) && (r_rd_data.max_x > {1'b0, r_px}) &&
                   (r_rd_data.min_y < r_py) && (r_rd_data.max_y > {1'b0, r_py});

    // bounds kept one bit wider so the sums never wrap
    always_comb begin
        wr_data.min_x     = i_left;
        wr_data.max_x     = {1'b0, i_left} + {1'b0, i_width};
        wr_data.min_y     = i_top;
        wr_data.max_y     = {1'b0, i_top} + {1'b0, i_height};
        wr_data.tag_one   = i_tag_one;
        wr_data.tag_two   = i_tag_two;
        wr_data.tag_three = i_tag_three;
    end

    assign wr_en = accept && (i_cmd == CMD_ADD) && !table_full;
    assign rd_en = (r_state == S_SCAN) && (r_idx < r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_pend   = 1'b0;
        n_px        = r_px;
        n_py        = r_py;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // output register drains independently of the sequencer
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    unique case (i_cmd)
                        CMD_CLEAR: begin
                            n_count            = '0;
                            n_res.region_count = '0;
                            n_state            = S_DONE;
                        end
                        CMD_ADD: begin
                            if (table_full) begin
                                n_res.full_res = 1'b1;
                                n_res.region_count = r_count;
                            end else begin
                                n_count            = r_count + 1'b1;
                                n_res.region_count = r_count + 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        CMD_TEST: begin
                            n_px               = i_point_x;
                            n_py               = i_point_y;
                            n_idx              = '0;
                            n_res.region_count = r_count;
                            n_state            = S_SCAN;
                        end
                        default: begin
                            // unused code: table untouched, count only
                            n_res.region_count = r_count;
                            n_state            = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_rd_pend = rd_en;
                if (rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                // first match wins, entries come back in insertion order
                if (r_rd_pend && match) begin
                    n_res.hit         = 1'b1;
                    n_res.found_one   = r_rd_data.tag_one;
                    n_res.found_two   = r_rd_data.tag_two;
                    n_res.found_three = r_rd_data.tag_three;
                    n_rd_pend         = 1'b0;
                    n_state           = S_DONE;
                end else if (!rd_en && !r_rd_pend) begin
                    // every stored entry checked, or the table is empty
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_px  <= n_px;
        r_py  <= n_py;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out.hit;
    assign o_full_res     = r_out.full_res;
    assign o_found_one    = r_out.found_one;
    assign o_found_two    = r_out.found_two;
    assign o_found_three  = r_out.found_three;
    assign o_region_count = r_out.region_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGIONS))
        else $error("fill count beyond table size");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index ran past fill count");

    a_hit_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_region_count != '0 && !o_full_res))
        else $error("hit reported with empty table or together with full");

    a_full_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_region_count == CNT_W'(MAX_REGIONS)))
        else $error("full reported below table size");

    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_DONE && r_count == $past(r_count) + 1'b1))
        else $error("table write did not advance fill count");
`endif

endmodule

`default_nettype wire
